[src/spt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants of the stereo point triangulator.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int RAY_W      = 33;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [2:0] REG_LEFT_FOCAL_X   = 3'd0;
    localparam logic [2:0] REG_LEFT_FOCAL_Y   = 3'd1;
    localparam logic [2:0] REG_LEFT_PRINCIPAL = 3'd2;
    localparam logic [2:0] REG_RIGHT_FOCAL_X  = 3'd3;
    localparam logic [2:0] REG_RIGHT_FOCAL_Y  = 3'd4;
    localparam logic [2:0] REG_RIGHT_PRINCIPAL = 3'd5;
    localparam logic [2:0] REG_BASELINE       = 3'd6;

    localparam logic [15:0] FOCAL_RESET    = 16'd8192;
    localparam logic [31:0] BASELINE_RESET = 32'd65536;

    typedef struct packed {
        logic [15:0] left_focal_x;
        logic [15:0] left_focal_y;
        logic [31:0] left_principal;
        logic [15:0] right_focal_x;
        logic [15:0] right_focal_y;
        logic [31:0] right_principal;
        logic [31:0] baseline;
    } t_cfg;

    typedef struct packed {
        logic signed [RAY_W-1:0] lx;
        logic signed [RAY_W-1:0] ly;
        logic signed [RAY_W-1:0] rx;
        logic signed [RAY_W-1:0] ry;
    } t_rays;

endpackage

[src/spt_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_in_if
// Pixel pair channel: valid/ready with left and right image points.
// ----------------------------------------------------------------------------
interface spt_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic [15:0] right_y;

    modport source (output valid, left_x, left_y, right_x, right_y, input ready);
    modport sink   (input valid, left_x, left_y, right_x, right_y, output ready);
endinterface

[src/spt_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_out_if
// Point channel: valid/ready with the triangulated point.
// ----------------------------------------------------------------------------
interface spt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_depth;
    logic               degenerate;

    modport source (output valid, point_x, point_y, point_depth, degenerate, input ready);
    modport sink   (input valid, point_x, point_y, point_depth, degenerate, output ready);
endinterface

[src/spt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module spt_div #(
    parameter int DW = 16,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_nq,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [QW];
    logic [QW-1:0] r_nq   [QW];
    logic [SW-1:0] r_side [QW];
    logic [DW-1:0] r_rem  [QW-1];
    logic [DW-1:0] r_den  [QW-1];

    logic          w_vld_in  [QW];
    logic [QW-1:0] w_nq_in   [QW];
    logic [SW-1:0] w_side_in [QW];
    logic [DW-1:0] w_rem_in  [QW];
    logic [DW-1:0] w_den_in  [QW];
    logic [QW-1:0] n_nq      [QW];
    logic [DW-1:0] n_rem     [QW-1];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW:0] w_t;
        logic [DW:0] w_d;
        logic        w_ge;

        if (s == 0) begin : g_first
            assign w_vld_in[s]  = i_valid;
            assign w_nq_in[s]   = i_nq;
            assign w_side_in[s] = i_side;
            assign w_rem_in[s]  = i_rem;
            assign w_den_in[s]  = i_den;
        end else begin : g_next
            assign w_vld_in[s]  = r_vld[s-1];
            assign w_nq_in[s]   = r_nq[s-1];
            assign w_side_in[s] = r_side[s-1];
            assign w_rem_in[s]  = r_rem[s-1];
            assign w_den_in[s]  = r_den[s-1];
        end

        assign w_t     = {w_rem_in[s], w_nq_in[s][QW-1]};
        assign w_d     = w_t - {1'b0, w_den_in[s]};
        assign w_ge    = (w_t >= {1'b0, w_den_in[s]});
        assign n_nq[s] = {w_nq_in[s][QW-2:0], w_ge};

        if (s < QW - 1) begin : g_rem
            assign n_rem[s] = w_ge ? w_d[DW-1:0] : w_t[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QW; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_vld[s] <= w_vld_in[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_nq[s]   <= n_nq[s];
                r_side[s] <= w_side_in[s];
            end
            for (int s = 0; s < QW - 1; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= w_den_in[s];
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_nq[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

[src/spt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_front
// Accepts pixel pairs and turns each pixel into a normalized Q16.16 ray.
// ----------------------------------------------------------------------------
module spt_front import spt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    spt_in_if.sink     i_pix,
    output logic       o_valid,
    output t_rays      o_rays,
    input  logic       i_ready
);

    logic        w_en;
    logic [15:0] w_pix [4];
    logic [15:0] w_cen [4];
    logic [15:0] w_foc [4];
    logic [3:0]  w_vld;
    logic signed [RAY_W-1:0] w_ray [4];

    assign w_en        = !(o_valid && !i_ready);
    assign i_pix.ready = w_en;

    always_comb begin
        w_pix[0] = i_pix.left_x;
        w_pix[1] = i_pix.left_y;
        w_pix[2] = i_pix.right_x;
        w_pix[3] = i_pix.right_y;
        w_cen[0] = i_cfg.left_principal[15:0];
        w_cen[1] = i_cfg.left_principal[31:16];
        w_cen[2] = i_cfg.right_principal[15:0];
        w_cen[3] = i_cfg.right_principal[31:16];
        w_foc[0] = i_cfg.left_focal_x;
        w_foc[1] = i_cfg.left_focal_y;
        w_foc[2] = i_cfg.right_focal_x;
        w_foc[3] = i_cfg.right_focal_y;
    end

    for (genvar k = 0; k < 4; k++) begin : g_ray
        logic [16:0] w_diff;
        logic [16:0] w_ndiff;
        logic [15:0] w_mag;
        logic [15:0] w_den;
        logic [31:0] w_quo;
        logic        w_neg;

        assign w_diff  = {1'b0, w_pix[k]} - {1'b0, w_cen[k]};
        assign w_ndiff = 17'd0 - w_diff;
        assign w_mag   = w_diff[16] ? w_ndiff[15:0] : w_diff[15:0];
        // focal of zero behaves as one
        assign w_den   = (w_foc[k] == 16'd0) ? 16'd1 : w_foc[k];

        spt_div #(.DW(16), .QW(32), .SW(1)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (i_pix.valid),
            .i_rem   (16'd0),
            .i_nq    ({w_mag, 16'd0}),
            .i_den   (w_den),
            .i_side  (w_diff[16]),
            .o_valid (w_vld[k]),
            .o_quo   (w_quo),
            .o_side  (w_neg)
        );

        assign w_ray[k] = w_neg ? (33'sd0 - $signed({1'b0, w_quo})) : $signed({1'b0, w_quo});
    end

    assign o_valid   = &w_vld;
    assign o_rays.lx = w_ray[0];
    assign o_rays.ly = w_ray[1];
    assign o_rays.rx = w_ray[2];
    assign o_rays.ry = w_ray[3];

endmodule

[src/spt_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_fifo
// Short ray queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module spt_fifo import spt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_rays i_push_data,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_rays o_pop_data,
    input  logic  i_pop
);

    t_rays              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_cnt != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (FIFO_AW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (FIFO_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

[src/spt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_back
// Geometry pipeline: cross products, depth division, scaling, saturation.
// ----------------------------------------------------------------------------
module spt_back import spt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  t_rays      i_rays,
    output logic       o_pop,
    spt_out_if.source  o_pt
);

    typedef struct packed {
        logic                    degen;
        logic                    ovf;
        logic                    sneg;
        logic signed [RAY_W-1:0] rx;
        logic signed [RAY_W-1:0] ry;
    } t_side;

    localparam int SIDE_W = $bits(t_side);
    localparam logic [63:0] SQ_MAX = 64'h8000_0000_0000_0000;

    function automatic logic [31:0] sat32(input logic neg, input logic [79:0] m);
        logic [31:0] v;
        v = 32'd0 - m[31:0];
        if (!neg) begin
            return (m > 80'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        end
        return (m >= 80'h8000_0000) ? 32'h8000_0000 : v;
    endfunction

    logic       w_en;
    logic [8:0] r_vb;
    logic [2:0] r_vc;
    logic       r_ov;

    assign w_en  = !r_ov || o_pt.ready;
    assign o_pop = w_en;

    // B1
    logic signed [65:0] r1_p1, r1_p2;
    logic [33:0]        r1_a0, r1_a1, r1_dx;
    logic signed [RAY_W-1:0] r1_rx, r1_ry;
    // B2
    logic [48:0]        r2_a2m;
    logic               r2_a2n;
    logic [65:0]        r2_a0sq, r2_a1sq;
    logic [33:0]        r2_dx;
    logic signed [RAY_W-1:0] r2_rx, r2_ry;
    // B3
    logic [63:0]        r3_ll, r3_pl;
    logic [48:0]        r3_hl, r3_ph;
    logic [33:0]        r3_hh;
    logic [66:0]        r3_s01;
    logic               r3_kneg;
    logic [33:0]        r3_dx;
    logic signed [RAY_W-1:0] r3_rx, r3_ry;
    // B4
    logic [98:0]        r4_dd;
    logic [80:0]        r4_a2ry;
    logic               r4_kneg;
    logic [33:0]        r4_dx;
    logic signed [RAY_W-1:0] r4_rx, r4_ry;
    // B5
    logic [82:0]        r5_kk;
    logic [98:0]        r5_dd;
    logic               r5_degen;
    logic signed [RAY_W-1:0] r5_rx, r5_ry;
    // B6
    logic [81:0]        r6_nm;
    logic               r6_sneg;
    logic [98:0]        r6_dd;
    logic               r6_degen;
    logic signed [RAY_W-1:0] r6_rx, r6_ry;
    // B7
    logic [63:0]        r7_c0, r7_c1;
    logic [49:0]        r7_c2;
    logic               r7_sneg;
    logic [98:0]        r7_dd;
    logic               r7_degen;
    logic signed [RAY_W-1:0] r7_rx, r7_ry;
    // B8
    logic [113:0]       r8_nm;
    logic               r8_sneg;
    logic [98:0]        r8_dd;
    logic               r8_degen;
    logic signed [RAY_W-1:0] r8_rx, r8_ry;
    // B9
    logic [98:0]        r9_rem;
    logic [63:0]        r9_nq;
    logic [98:0]        r9_dd;
    t_side              r9_side;
    // C1..C3
    logic [63:0]        r10_sq;
    t_side              r10_side;
    logic [63:0]        r11_xl, r11_xh, r11_yl, r11_yh;
    t_side              r11_side;
    logic [63:0]        r11_sq;
    logic [95:0]        r12_px, r12_py;
    t_side              r12_side;
    logic [63:0]        r12_sq;
    // output
    logic signed [31:0] r_px, r_py, r_pd;
    logic               r_dg;

    // combinational terms
    logic signed [65:0] w_p1, w_p2;
    logic [66:0]        w_a2w, w_a2abs;
    logic [33:0]        w_a0abs, w_a1abs;
    logic [32:0]        w_ryabs3;
    logic [82:0]        w_dxs, w_term, w_kabs;
    logic [49:0]        w_top;
    logic               w_ovf;
    logic               w_dv;
    logic [63:0]        w_quo;
    logic [SIDE_W-1:0]  w_dside;
    t_side              w_side;
    logic [63:0]        w_sq;
    logic [32:0]        w_rxa, w_rya;

    assign w_p1     = 66'(i_rays.rx) * 66'(i_rays.ly);
    assign w_p2     = 66'(i_rays.ry) * 66'(i_rays.lx);
    assign w_a2w    = {r1_p1[65], r1_p1} - {r1_p2[65], r1_p2};
    assign w_a2abs  = w_a2w[66] ? (67'd0 - w_a2w) : w_a2w;
    assign w_a0abs  = r1_a0[33] ? (34'd0 - r1_a0) : r1_a0;
    assign w_a1abs  = r1_a1[33] ? (34'd0 - r1_a1) : r1_a1;
    assign w_ryabs3 = r2_ry[32] ? (33'd0 - r2_ry) : r2_ry;
    assign w_dxs    = {{33{r4_dx[33]}}, r4_dx, 16'd0};
    assign w_term   = r4_kneg ? (83'd0 - 83'(r4_a2ry)) : 83'(r4_a2ry);
    assign w_kabs   = r5_kk[82] ? (83'd0 - r5_kk) : r5_kk;
    assign w_top    = r8_nm[113:64];
    assign w_ovf    = ({49'd0, w_top} >= r8_dd);
    assign w_side   = t_side'(w_dside);
    assign w_sq     = (w_side.ovf || (w_quo > SQ_MAX)) ? SQ_MAX : w_quo;
    assign w_rxa    = r10_side.rx[32] ? (33'd0 - r10_side.rx) : r10_side.rx;
    assign w_rya    = r10_side.ry[32] ? (33'd0 - r10_side.ry) : r10_side.ry;

    spt_div #(.DW(99), .QW(64), .SW(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vb[8]),
        .i_rem   (r9_rem),
        .i_nq    (r9_nq),
        .i_den   (r9_dd),
        .i_side  (r9_side),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_side  (w_dside)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
            r_vc <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_vb <= {r_vb[7:0], i_valid};
            r_vc <= {r_vc[1:0], w_dv};
            r_ov <= r_vc[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_p1 <= w_p1;
            r1_p2 <= w_p2;
            r1_a0 <= {i_rays.ry[32], i_rays.ry} - {i_rays.ly[32], i_rays.ly};
            r1_a1 <= {i_rays.lx[32], i_rays.lx} - {i_rays.rx[32], i_rays.rx};
            r1_dx <= {i_rays.rx[32], i_rays.rx} - {i_rays.lx[32], i_rays.lx};
            r1_rx <= i_rays.rx;
            r1_ry <= i_rays.ry;

            r2_a2m  <= w_a2abs[64:16];
            r2_a2n  <= w_a2w[66];
            r2_a0sq <= 66'(w_a0abs[32:0]) * 66'(w_a0abs[32:0]);
            r2_a1sq <= 66'(w_a1abs[32:0]) * 66'(w_a1abs[32:0]);
            r2_dx   <= r1_dx;
            r2_rx   <= r1_rx;
            r2_ry   <= r1_ry;

            r3_ll   <= 64'(r2_a2m[31:0]) * 64'(r2_a2m[31:0]);
            r3_hl   <= 49'(r2_a2m[48:32]) * 49'(r2_a2m[31:0]);
            r3_hh   <= 34'(r2_a2m[48:32]) * 34'(r2_a2m[48:32]);
            r3_pl   <= 64'(r2_a2m[31:0]) * 64'(w_ryabs3[31:0]);
            r3_ph   <= 49'(r2_a2m[48:32]) * 49'(w_ryabs3[31:0]);
            r3_s01  <= {1'b0, r2_a0sq} + {1'b0, r2_a1sq};
            r3_kneg <= r2_a2n ^ r2_ry[32];
            r3_dx   <= r2_dx;
            r3_rx   <= r2_rx;
            r3_ry   <= r2_ry;

            r4_dd   <= 99'(r3_s01) + 99'(r3_ll) + (99'(r3_hl) << 33) + (99'(r3_hh) << 64);
            r4_a2ry <= 81'(r3_pl) + (81'(r3_ph) << 32);
            r4_kneg <= r3_kneg;
            r4_dx   <= r3_dx;
            r4_rx   <= r3_rx;
            r4_ry   <= r3_ry;

            r5_kk    <= w_dxs + w_term;
            r5_dd    <= r4_dd;
            r5_degen <= (r4_dd == 99'd0);
            r5_rx    <= r4_rx;
            r5_ry    <= r4_ry;

            r6_nm    <= w_kabs[81:0];
            r6_sneg  <= r5_kk[82];
            r6_dd    <= r5_dd;
            r6_degen <= r5_degen;
            r6_rx    <= r5_rx;
            r6_ry    <= r5_ry;

            r7_c0    <= 64'(r6_nm[31:0]) * 64'(i_cfg.baseline);
            r7_c1    <= 64'(r6_nm[63:32]) * 64'(i_cfg.baseline);
            r7_c2    <= 50'(r6_nm[81:64]) * 50'(i_cfg.baseline);
            r7_sneg  <= r6_sneg;
            r7_dd    <= r6_dd;
            r7_degen <= r6_degen;
            r7_rx    <= r6_rx;
            r7_ry    <= r6_ry;

            r8_nm    <= 114'(r7_c0) + (114'(r7_c1) << 32) + (114'(r7_c2) << 64);
            r8_sneg  <= r7_sneg;
            r8_dd    <= r7_dd;
            r8_degen <= r7_degen;
            r8_rx    <= r7_rx;
            r8_ry    <= r7_ry;

            // quotient of 2^64 or more saturates, so the divider sees rem < den
            r9_rem        <= w_ovf ? 99'd0 : {49'd0, w_top};
            r9_nq         <= r8_nm[63:0];
            r9_dd         <= r8_dd;
            r9_side.degen <= r8_degen;
            r9_side.ovf   <= w_ovf;
            r9_side.sneg  <= r8_sneg;
            r9_side.rx    <= r8_rx;
            r9_side.ry    <= r8_ry;

            r10_sq   <= w_sq;
            r10_side <= w_side;

            r11_xl   <= 64'(r10_sq[31:0]) * 64'(w_rxa[31:0]);
            r11_xh   <= 64'(r10_sq[63:32]) * 64'(w_rxa[31:0]);
            r11_yl   <= 64'(r10_sq[31:0]) * 64'(w_rya[31:0]);
            r11_yh   <= 64'(r10_sq[63:32]) * 64'(w_rya[31:0]);
            r11_side <= r10_side;
            r11_sq   <= r10_sq;

            r12_px   <= 96'(r11_xl) + (96'(r11_xh) << 32);
            r12_py   <= 96'(r11_yl) + (96'(r11_yh) << 32);
            r12_side <= r11_side;
            r12_sq   <= r11_sq;

            if (r12_side.degen) begin
                r_px <= 32'sd0;
                r_py <= 32'sd0;
                r_pd <= 32'sd0;
                r_dg <= 1'b1;
            end else begin
                r_px <= sat32(r12_side.sneg ^ r12_side.rx[32], r12_px[95:16]);
                r_py <= sat32(r12_side.sneg ^ r12_side.ry[32], r12_py[95:16]);
                r_pd <= sat32(r12_side.sneg, {16'd0, r12_sq});
                r_dg <= 1'b0;
            end
        end
    end

    assign o_pt.valid       = r_ov;
    assign o_pt.point_x     = r_px;
    assign o_pt.point_y     = r_py;
    assign o_pt.point_depth = r_pd;
    assign o_pt.degenerate  = r_dg;

endmodule

[src/stereo_point_triangulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_point_triangulator
// Triangulates a matched left/right pixel pair into a Q16.16 3D point.
// ----------------------------------------------------------------------------
// Fully pipelined: one pixel pair is taken every cycle unless stalled, and one
// point comes out per pair, in order. Each result passes the 32-stage ray
// dividers in the front, the one-entry minimum pass through the ray queue, and
// the 64-stage depth divider in the back with its surrounding multiply stages.
// Either side may stall; the four-entry queue lets the front keep taking items
// while the back waits on the output. Configuration registers are written
// through a plain write port by the user, only while idle; block doesn't check.
// ----------------------------------------------------------------------------
module stereo_point_triangulator import spt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spt_in_if.sink      i_pix,
    spt_out_if.source   o_pt,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_fr_valid;
    t_rays w_fr_rays;
    logic  w_q_ready;
    logic  w_q_valid;
    t_rays w_q_rays;
    logic  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_focal_x    <= FOCAL_RESET;
            r_cfg.left_focal_y    <= FOCAL_RESET;
            r_cfg.left_principal  <= 32'd0;
            r_cfg.right_focal_x   <= FOCAL_RESET;
            r_cfg.right_focal_y   <= FOCAL_RESET;
            r_cfg.right_principal <= 32'd0;
            r_cfg.baseline        <= BASELINE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEFT_FOCAL_X:    r_cfg.left_focal_x    <= i_cfg_data[15:0];
                REG_LEFT_FOCAL_Y:    r_cfg.left_focal_y    <= i_cfg_data[15:0];
                REG_LEFT_PRINCIPAL:  r_cfg.left_principal  <= i_cfg_data;
                REG_RIGHT_FOCAL_X:   r_cfg.right_focal_x   <= i_cfg_data[15:0];
                REG_RIGHT_FOCAL_Y:   r_cfg.right_focal_y   <= i_cfg_data[15:0];
                REG_RIGHT_PRINCIPAL: r_cfg.right_principal <= i_cfg_data;
                REG_BASELINE:        r_cfg.baseline        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    spt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pix   (i_pix),
        .o_valid (w_fr_valid),
        .o_rays  (w_fr_rays),
        .i_ready (w_q_ready)
    );

    spt_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_fr_valid),
        .i_push_data  (w_fr_rays),
        .o_push_ready (w_q_ready),
        .o_pop_valid  (w_q_valid),
        .o_pop_data   (w_q_rays),
        .i_pop        (w_pop)
    );

    spt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_valid),
        .i_rays  (w_q_rays),
        .o_pop   (w_pop),
        .o_pt    (o_pt)
    );

endmodule

[src/spt_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_chk
// Port-level checks of the triangulator output channel.
// ----------------------------------------------------------------------------
module spt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_point_x,
    input logic [31:0] i_point_y,
    input logic [31:0] i_point_depth,
    input logic        i_degenerate
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("output item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_point_x) && $stable(i_point_y)
            && $stable(i_point_depth) && $stable(i_degenerate))
        else $error("output item changed while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_degenerate |-> i_point_x == 32'd0 && i_point_y == 32'd0
            && i_point_depth == 32'd0)
        else $error("degenerate item with nonzero point");

    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_degenerate && i_point_depth == 32'd0 |->
            i_point_x == 32'd0 && i_point_y == 32'd0)
        else $error("zero depth with nonzero point");

endmodule

bind stereo_point_triangulator spt_chk u_spt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_pt.valid),
    .i_ready       (o_pt.ready),
    .i_point_x     (o_pt.point_x),
    .i_point_y     (o_pt.point_y),
    .i_point_depth (o_pt.point_depth),
    .i_degenerate  (o_pt.degenerate)
);

[tb/sv/stereo_point_triangulator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_point_triangulator_tb
// Self-checking bench for the stereo point triangulator.
// ----------------------------------------------------------------------------
// Drives pixel pairs under random source gaps and sink stalls and predicts
// each 3D point with a wide-integer triangulation model kept in step with the
// calibration registers. Directed pairs cover the pixel extremes, equal rays
// (degenerate), zero focal lengths, zero and huge baselines, and an ignored
// register index; random phases then sweep calibration settings.
// ----------------------------------------------------------------------------
module stereo_point_triangulator_tb;
    import spt_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] depth;
        logic               degen;
    } t_point;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    spt_in_if  pix ();
    spt_out_if pt ();

    stereo_point_triangulator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_pt       (pt),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    localparam int         DRAIN_CYCLES = 150;
    localparam logic [2:0] REG_UNUSED   = 3'd7;

    t_cfg   calib;
    t_point pending_points[$];
    int     mismatches;
    int     max_gap;
    int     max_stall;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint make_ray(logic [15:0] p, logic [15:0] c, logic [15:0] f);
        longint d;
        longint m;
        longint ff;
        d  = longint'(p) - longint'(c);
        ff = (f == 16'd0) ? 64'sd1 : longint'(f);
        m  = ((d < 0 ? -d : d) <<< 16) / ff;
        return d < 0 ? -m : m;
    endfunction

    function automatic logic [31:0] sat32(logic neg, logic [255:0] m);
        if (!neg)
            return (m > 256'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
        if (m > 256'h80000000)
            m = 256'h80000000;
        return -m[31:0];
    endfunction

    function automatic t_point triangulate(logic [15:0] plx, logic [15:0] ply,
                                           logic [15:0] prx, logic [15:0] pry);
        logic signed [127:0] lx, ly, rx, ry, a0, a1, a2, a2w, kk;
        logic [127:0] a2m, dd, nm, q;
        logic [63:0]  sq;
        logic [255:0] rxm, rym;
        logic         sneg;
        t_point       p;
        lx  = 128'(make_ray(plx, calib.left_principal[15:0], calib.left_focal_x));
        ly  = 128'(make_ray(ply, calib.left_principal[31:16], calib.left_focal_y));
        rx  = 128'(make_ray(prx, calib.right_principal[15:0], calib.right_focal_x));
        ry  = 128'(make_ray(pry, calib.right_principal[31:16], calib.right_focal_y));
        a0  = ry - ly;
        a1  = lx - rx;
        a2w = rx * ly - ry * lx;
        a2m = (a2w < 0) ? -a2w : a2w;
        a2m = a2m >> 16;
        a2  = (a2w < 0) ? -$signed(a2m) : $signed(a2m);
        dd  = a0 * a0 + a1 * a1 + a2 * a2;
        if (dd == 0) begin
            p.x = 32'sd0; p.y = 32'sd0; p.depth = 32'sd0; p.degen = 1'b1;
            return p;
        end
        kk   = (rx - lx) * 65536 + a2 * ry;
        sneg = kk < 0;
        nm   = (kk < 0) ? -kk : kk;
        nm   = nm * {96'd0, calib.baseline};
        q    = nm / dd;
        sq   = (q > 128'h8000000000000000) ? 64'h8000000000000000 : q[63:0];
        rxm  = 256'((rx < 0) ? -rx : rx);
        rym  = 256'((ry < 0) ? -ry : ry);
        p.x     = sat32(sneg != (rx < 0), ({192'd0, sq} * rxm) >> 16);
        p.y     = sat32(sneg != (ry < 0), ({192'd0, sq} * rym) >> 16);
        p.depth = sat32(sneg, {192'd0, sq});
        p.degen = 1'b0;
        return p;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_LEFT_FOCAL_X:    calib.left_focal_x    = data[15:0];
            REG_LEFT_FOCAL_Y:    calib.left_focal_y    = data[15:0];
            REG_LEFT_PRINCIPAL:  calib.left_principal  = data;
            REG_RIGHT_FOCAL_X:   calib.right_focal_x   = data[15:0];
            REG_RIGHT_FOCAL_Y:   calib.right_focal_y   = data[15:0];
            REG_RIGHT_PRINCIPAL: calib.right_principal = data;
            REG_BASELINE:        calib.baseline        = data;
            default: ;
        endcase
    endtask

    // drop valid and let every outstanding point come back
    task automatic drain_points();
        pix.valid = 1'b0;
        while (pending_points.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_pair(logic [15:0] lx, logic [15:0] ly,
                             logic [15:0] rx, logic [15:0] ry);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0) begin
            pix.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix.valid   = 1'b1;
        pix.left_x  = lx;
        pix.left_y  = ly;
        pix.right_x = rx;
        pix.right_y = ry;
        do
            @(posedge i_clk);
        while (!pix.ready);
        pending_points.insert(pending_points.size(), triangulate(lx, ly, rx, ry));
        @(negedge i_clk);
    endtask

    task automatic send_random_pair();
        logic [15:0] lx, ly, rx, ry;
        lx = 16'($urandom);
        ly = 16'($urandom);
        if ($urandom_range(0, 9) < 6) begin
            rx = 16'(lx - $urandom_range(0, 2000));
            ry = 16'(ly + $urandom_range(0, 8) - 4);
        end else if ($urandom_range(0, 3) == 0) begin
            rx = lx;
            ry = ly;
        end else begin
            rx = 16'($urandom);
            ry = 16'($urandom);
        end
        send_pair(lx, ly, rx, ry);
    endtask

    task automatic test_reset_calibration();
        send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pair(16'h1000, 16'h0800, 16'h0F00, 16'h0800);
        send_pair(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_pair(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
        send_pair(16'h0010, 16'h0010, 16'h0000, 16'h0010);
    endtask

    task automatic test_calibration_extremes();
        drain_points();
        write_reg(REG_LEFT_FOCAL_X, 32'd0);
        write_reg(REG_LEFT_FOCAL_Y, 32'd1);
        write_reg(REG_RIGHT_FOCAL_X, 32'hFFFF);
        write_reg(REG_RIGHT_FOCAL_Y, 32'd0);
        write_reg(REG_LEFT_PRINCIPAL, 32'hFFFF_FFFF);
        write_reg(REG_RIGHT_PRINCIPAL, 32'h0000_0000);
        write_reg(REG_BASELINE, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'h1234_5678);
        send_pair(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_pair(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_pair(16'h0001, 16'hFFFE, 16'h0002, 16'h0001);
        send_pair(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        drain_points();
        write_reg(REG_BASELINE, 32'd0);
        write_reg(REG_LEFT_PRINCIPAL, 32'h0800_0800);
        write_reg(REG_RIGHT_PRINCIPAL, 32'h0800_0800);
        write_reg(REG_LEFT_FOCAL_X, 32'hFFFF);
        write_reg(REG_LEFT_FOCAL_Y, 32'hFFFF);
        write_reg(REG_RIGHT_FOCAL_X, 32'hFFFF);
        write_reg(REG_RIGHT_FOCAL_Y, 32'hFFFF);
        send_pair(16'h0900, 16'h0800, 16'h0700, 16'h0800);
        send_pair(16'h0800, 16'h0800, 16'h0800, 16'h0800);
        drain_points();
        write_reg(REG_BASELINE, 32'hFFFF_FFFF);
        write_reg(REG_LEFT_FOCAL_X, 32'd1);
        write_reg(REG_RIGHT_FOCAL_X, 32'd1);
        send_pair(16'hFFFF, 16'h0900, 16'h0000, 16'h0900);
        send_pair(16'h0801, 16'h0801, 16'h0800, 16'h0800);
        send_pair(16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
    endtask

    task automatic test_random_phase(int count, logic wild_cal);
        drain_points();
        if (wild_cal) begin
            write_reg(REG_LEFT_FOCAL_X, $urandom_range(0, 65535));
            write_reg(REG_LEFT_FOCAL_Y, $urandom_range(0, 65535));
            write_reg(REG_RIGHT_FOCAL_X, $urandom_range(0, 65535));
            write_reg(REG_RIGHT_FOCAL_Y, $urandom_range(0, 65535));
            write_reg(REG_LEFT_PRINCIPAL, $urandom);
            write_reg(REG_RIGHT_PRINCIPAL, $urandom);
            write_reg(REG_BASELINE, $urandom);
        end else begin
            logic [15:0] f;
            logic [31:0] c;
            f = 16'($urandom_range(2000, 20000));
            c = {16'($urandom_range(0, 16'h3000)), 16'($urandom_range(0, 16'h5000))};
            write_reg(REG_LEFT_FOCAL_X, {16'd0, f});
            write_reg(REG_LEFT_FOCAL_Y, {16'd0, f});
            write_reg(REG_RIGHT_FOCAL_X, {16'd0, f});
            write_reg(REG_RIGHT_FOCAL_Y, {16'd0, f});
            write_reg(REG_LEFT_PRINCIPAL, c);
            write_reg(REG_RIGHT_PRINCIPAL, c);
            write_reg(REG_BASELINE, $urandom_range(1, 32'h0010_0000));
        end
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                max_gap   = ($urandom_range(0, 2) == 0) ? 0 : 12;
                max_stall = ($urandom_range(0, 2) == 0) ? 0 : 12;
            end
            if (n == count / 2 && wild_cal)
                drain_points();
            send_random_pair();
        end
    endtask

    // output side: random stall before each point, check on acceptance
    initial begin
        int     stall;
        t_point want;
        pt.ready = 1'b0;
        forever begin
            stall = (max_stall == 0) ? 0 : $urandom_range(0, max_stall);
            pt.ready = 1'b0;
            repeat (stall) @(negedge i_clk);
            pt.ready = 1'b1;
            do
                @(posedge i_clk);
            while (!pt.valid);
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%0d y=%0d d=%0d degen=%0b",
                             pt.point_x, pt.point_y, pt.point_depth, pt.degenerate);
            end else begin
                want = pending_points.pop_front();
                if (pt.point_x !== want.x || pt.point_y !== want.y ||
                    pt.point_depth !== want.depth || pt.degenerate !== want.degen) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"point mismatch: exp x=%0d y=%0d d=%0d degen=%0b, ",
                                  "got x=%0d y=%0d d=%0d degen=%0b"},
                                 want.x, want.y, want.depth, want.degen,
                                 pt.point_x, pt.point_y, pt.point_depth, pt.degenerate);
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        #5ms;
        $display("[stereo_point_triangulator] ERROR");
        $finish;
    end

    initial begin
        mismatches  = 0;
        max_gap     = 12;
        max_stall   = 12;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_LEFT_FOCAL_X;
        i_cfg_data  = 32'd0;
        pix.valid   = 1'b0;
        pix.left_x  = 16'd0;
        pix.left_y  = 16'd0;
        pix.right_x = 16'd0;
        pix.right_y = 16'd0;
        calib = '{left_focal_x: FOCAL_RESET, left_focal_y: FOCAL_RESET, left_principal: 32'd0,
                  right_focal_x: FOCAL_RESET, right_focal_y: FOCAL_RESET,
                  right_principal: 32'd0, baseline: BASELINE_RESET};
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_calibration();
        test_calibration_extremes();
        for (int ph = 0; ph < 8; ph++)
            test_random_phase(235, ph % 2 == 1);

        drain_points();
        if (mismatches == 0 && pending_points.size() == 0)
            $display("[stereo_point_triangulator] OK");
        else
            $display("[stereo_point_triangulator] ERROR");
        $finish;
    end
endmodule

[filelist.f]
src/spt_pkg.sv
src/spt_in_if.sv
src/spt_out_if.sv
src/spt_div.sv
src/spt_front.sv
src/spt_fifo.sv
src/spt_back.sv
src/stereo_point_triangulator.sv
src/spt_chk.sv
tb/sv/stereo_point_triangulator_tb.sv
